/* src/lplr_pkg.sv */
// shared constants, types and helpers for the low-pass linear resampler
package lplr_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 24;
    localparam int COEF_FRAC  = 22;
    localparam int STATE_W    = 32;
    localparam int SUM_W      = 60;
    localparam int PHASE_W    = 21;
    localparam int PHASE_FRAC = 16;
    localparam int MCNT_W     = $clog2(COEF_W);
    localparam int CFG_IDX_W  = 3;
    localparam int DIFF_W     = SAMPLE_W + 1;

    localparam logic [PHASE_W-1:0] PHASE_ONE  = PHASE_W'(1) << PHASE_FRAC;
    localparam logic [PHASE_W-1:0] STEP_MIN   = PHASE_W'(32768);
    localparam logic [PHASE_W-1:0] STEP_MAX   = PHASE_W'(1048576);
    localparam logic [PHASE_W-1:0] STEP_RESET = PHASE_W'(196608);

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TWO_CH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_B0     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_B1     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_B2     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_A1     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_A2     = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STEP,
        ST_WAIT,
        ST_EMIT,
        ST_IWAIT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic                     enable;
        logic                     two_ch;
        logic [PHASE_W-1:0]       step;
        logic signed [COEF_W-1:0] b0;
        logic signed [COEF_W-1:0] b1;
        logic signed [COEF_W-1:0] b2;
        logic signed [COEF_W-1:0] a1;
        logic signed [COEF_W-1:0] a2;
    } t_cfg;

    typedef struct packed {
        logic start;
        logic init_en;
        logic sub;
    } t_mac_req;

    // round half up, drop the coefficient fraction, saturate to state width
    function automatic logic signed [STATE_W-1:0] round_sat(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-1:0]           t;
        logic signed [SUM_W-COEF_FRAC-1:0] sh;
        logic signed [SUM_W-COEF_FRAC-1:0] hi;
        logic signed [SUM_W-COEF_FRAC-1:0] lo;
        t  = s + (SUM_W'(1) <<< (COEF_FRAC - 1));
        sh = (SUM_W-COEF_FRAC)'(t >>> COEF_FRAC);
        hi = (SUM_W-COEF_FRAC)'({1'b0, {(STATE_W-1){1'b1}}});
        lo = -hi - 1;
        if (sh > hi) begin
            return {1'b0, {(STATE_W-1){1'b1}}};
        end else if (sh < lo) begin
            return {1'b1, {(STATE_W-1){1'b0}}};
        end
        return sh[STATE_W-1:0];
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] sat_sample(
        input logic signed [STATE_W-1:0] v
    );
        logic signed [STATE_W-1:0] hi;
        logic signed [STATE_W-1:0] lo;
        hi = STATE_W'({1'b0, {(SAMPLE_W-1){1'b1}}});
        lo = -hi - 1;
        if (v > hi) begin
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else if (v < lo) begin
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        end
        return v[SAMPLE_W-1:0];
    endfunction

endpackage

/* src/lplr_mac.sv */
// bit-serial multiply-accumulate unit, one multiplier bit per cycle
module lplr_mac import lplr_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_mac_req                  i_req,
    input  logic signed [SUM_W-1:0]   i_init,
    input  logic signed [STATE_W-1:0] i_a,
    input  logic signed [COEF_W-1:0]  i_b,
    output logic                      o_busy,
    output logic signed [SUM_W-1:0]   o_sum
);

    logic                    r_busy;
    logic [MCNT_W-1:0]       r_cnt;
    logic signed [SUM_W-1:0] r_a;
    logic [COEF_W-1:0]       r_b;
    logic                    r_sub;
    logic signed [SUM_W-1:0] r_sum;
    logic                    neg;
    logic signed [SUM_W-1:0] addend;

    // the top multiplier bit carries negative weight
    assign neg    = r_sub ^ (r_cnt == MCNT_W'(COEF_W - 1));
    assign addend = r_b[0] ? (neg ? -r_a : r_a) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == MCNT_W'(COEF_W - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_a   <= SUM_W'(i_a);
            r_b   <= i_b;
            r_sub <= i_req.sub;
            if (i_req.init_en) begin
                r_sum <= i_init;
            end
        end else if (r_busy) begin
            r_a   <= r_a <<< 1;
            r_b   <= r_b >> 1;
            r_sum <= r_sum + addend;
        end
    end

    assign o_busy = r_busy;
    assign o_sum  = r_sum;

endmodule

/* src/lplr_seq.sv */
// sequencer: mono mix, two biquad passes, phase stepping and output register
module lplr_seq import lplr_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_cfg                       i_cfg,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_left_sample,
    input  logic signed [SAMPLE_W-1:0] i_right_sample,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_out_sample,
    output logic                       o_last_of_run
);

    t_state r_state, n_state;
    logic [2:0] r_op;
    logic       r_stg;
    logic [1:0] r_cnt;
    logic [PHASE_W-1:0] r_phase;
    logic signed [STATE_W-1:0] r_x, r_y, r_n1;
    logic signed [STATE_W-1:0] r_acc1 [2];
    logic signed [STATE_W-1:0] r_acc2 [2];
    logic signed [SAMPLE_W-1:0] r_prev, r_cur;
    logic r_ov;
    logic signed [SAMPLE_W-1:0] r_osample;
    logic r_olast;

    t_mac_req mreq;
    logic signed [SUM_W-1:0]   minit;
    logic signed [STATE_W-1:0] ma;
    logic signed [COEF_W-1:0]  mb;
    logic                      mbusy;
    logic signed [SUM_W-1:0]   msum;

    logic accept, out_free, emit_more, new_last;
    logic [PHASE_W-1:0] step, phase_next;
    logic signed [SAMPLE_W:0] lr_sum;
    logic signed [SAMPLE_W-1:0] mono;
    logic signed [STATE_W-1:0] rounded;
    logic signed [DIFF_W-1:0] diff;
    logic signed [SUM_W-PHASE_FRAC-1:0] frac_part;
    logic signed [STATE_W-1:0] interp;

    lplr_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mreq),
        .i_init  (minit),
        .i_a     (ma),
        .i_b     (mb),
        .o_busy  (mbusy),
        .o_sum   (msum)
    );

    assign accept     = i_in_valid && !o_in_stall;
    assign out_free   = !r_ov || !i_out_stall;
    assign step       = (i_cfg.step < STEP_MIN) ? STEP_MIN :
                        (i_cfg.step > STEP_MAX) ? STEP_MAX : i_cfg.step;
    assign phase_next = r_phase + step;
    assign emit_more  = (r_phase < PHASE_ONE) && (r_cnt != 2'd2);
    assign new_last   = (phase_next >= PHASE_ONE) || (r_cnt == 2'd1);
    assign lr_sum     = (SAMPLE_W+1)'(i_left_sample) + (SAMPLE_W+1)'(i_right_sample);
    assign mono       = i_cfg.two_ch ? lr_sum[SAMPLE_W:1] : i_left_sample;
    assign rounded    = round_sat(msum);
    assign diff       = DIFF_W'(r_cur) - DIFF_W'(r_prev);
    assign frac_part  = (SUM_W-PHASE_FRAC)'(msum >>> PHASE_FRAC);
    assign interp     = STATE_W'(r_prev) + STATE_W'(frac_part);
    assign o_in_stall = (r_state != ST_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (accept && i_cfg.enable) n_state = ST_STEP;
            ST_STEP:  n_state = (r_op == 3'd5) ? (r_stg ? ST_EMIT : ST_STEP) : ST_WAIT;
            ST_WAIT:  if (!mbusy) n_state = ST_STEP;
            ST_EMIT:  n_state = emit_more ? ST_IWAIT : ST_IDLE;
            ST_IWAIT: if (!mbusy) n_state = ST_OUT;
            ST_OUT:   if (out_free) n_state = ST_EMIT;
            default:  n_state = ST_IDLE;
        endcase
    end

    // mac operand selection, at most one product per step
    always_comb begin
        mreq  = '0;
        minit = '0;
        ma    = r_x;
        mb    = i_cfg.b0;
        unique case (r_state)
            ST_STEP: begin
                case (r_op)
                    3'd0: begin
                        mreq  = '{start: 1'b1, init_en: 1'b1, sub: 1'b0};
                        minit = SUM_W'(r_acc1[r_stg]) <<< COEF_FRAC;
                    end
                    3'd1: begin
                        mreq  = '{start: 1'b1, init_en: 1'b1, sub: 1'b0};
                        minit = SUM_W'(r_acc2[r_stg]) <<< COEF_FRAC;
                        mb    = i_cfg.b1;
                    end
                    3'd2: begin
                        mreq = '{start: 1'b1, init_en: 1'b0, sub: 1'b1};
                        ma   = r_y;
                        mb   = i_cfg.a1;
                    end
                    3'd3: begin
                        mreq = '{start: 1'b1, init_en: 1'b1, sub: 1'b0};
                        mb   = i_cfg.b2;
                    end
                    3'd4: begin
                        mreq = '{start: 1'b1, init_en: 1'b0, sub: 1'b1};
                        ma   = r_y;
                        mb   = i_cfg.a2;
                    end
                    default: ;
                endcase
            end
            ST_EMIT: begin
                if (emit_more) begin
                    mreq  = '{start: 1'b1, init_en: 1'b1, sub: 1'b0};
                    minit = SUM_W'(32768);
                    ma    = STATE_W'(diff);
                    mb    = COEF_W'(r_phase[PHASE_FRAC-1:0]);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= '0;
            r_stg   <= 1'b0;
            r_cnt   <= '0;
            r_phase <= PHASE_ONE;
            r_acc1  <= '{default: '0};
            r_acc2  <= '{default: '0};
            r_prev  <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_OUT && out_free) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept && i_cfg.enable) begin
                        r_x   <= STATE_W'(mono);
                        r_op  <= '0;
                        r_stg <= 1'b0;
                        r_cnt <= '0;
                    end
                end
                ST_STEP: begin
                    case (r_op)
                        3'd1: r_y  <= rounded;
                        3'd3: r_n1 <= rounded;
                        default: ;
                    endcase
                    if (r_op == 3'd5) begin
                        r_acc1[r_stg] <= r_n1;
                        r_acc2[r_stg] <= rounded;
                        r_op          <= '0;
                        r_stg         <= 1'b1;
                        r_x           <= r_y;
                        r_cur         <= sat_sample(r_y);
                    end else begin
                        r_op <= r_op + 1'b1;
                    end
                end
                ST_WAIT: begin
                    // the final step rounds without another product
                    if (!mbusy && r_op == 3'd5) begin
                        r_op <= 3'd5;
                    end
                end
                ST_EMIT: begin
                    if (!emit_more) begin
                        r_phase <= r_phase - PHASE_ONE;
                        r_prev  <= r_cur;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_osample <= sat_sample(interp);
                        r_olast   <= new_last;
                        r_phase   <= phase_next;
                        r_cnt     <= r_cnt + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid   = r_ov;
    assign o_out_sample  = r_osample;
    assign o_last_of_run = r_olast;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mreq.start |-> !mbusy) else $error("mac started while busy");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("more than two results for one transaction");
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && out_free) |=> o_out_valid) else $error("result lost");
    a_idle_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !mreq.start) else $error("mac started while idle");

endmodule

/* src/mono_lowpass_linear_resampler_unit.sv */
// low-pass linear resampler: configuration registers and sequencer
// ten serial products per transaction, and one more per result, share one bit-serial
// mac; a new transaction is taken only once the previous one is done
// reset: synchronous active low; filter state and previous sample cleared,
// phase set to one, enable and two_channels set, step 3.0, coefficients zero
module mono_lowpass_linear_resampler_unit import lplr_pkg::*; (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic signed [SAMPLE_W-1:0] i_left_sample,
    input  logic signed [SAMPLE_W-1:0] i_right_sample,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic signed [SAMPLE_W-1:0] o_out_sample,
    output logic                       o_last_of_run,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [COEF_W-1:0]          i_cfg_data
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{enable: 1'b1, two_ch: 1'b1, step: STEP_RESET,
                       b0: '0, b1: '0, b2: '0, a1: '0, a2: '0};
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ENABLE: r_cfg.enable <= i_cfg_data[0];
                REG_TWO_CH: r_cfg.two_ch <= i_cfg_data[0];
                REG_STEP:   r_cfg.step   <= i_cfg_data[PHASE_W-1:0];
                REG_B0:     r_cfg.b0     <= i_cfg_data;
                REG_B1:     r_cfg.b1     <= i_cfg_data;
                REG_B2:     r_cfg.b2     <= i_cfg_data;
                REG_A1:     r_cfg.a1     <= i_cfg_data;
                REG_A2:     r_cfg.a2     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lplr_seq u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_sample   (o_out_sample),
        .o_last_of_run  (o_last_of_run)
    );

endmodule

/* tb/sv/tb_top.sv */
// testbench for the low-pass linear resampler: directed and random phases, self-checking
`timescale 1ns / 1ps

module tb_top;
    import lplr_pkg::*;

    typedef struct {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_resampled;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_in_valid;
    logic                       o_in_stall;
    logic signed [SAMPLE_W-1:0] i_left_sample;
    logic signed [SAMPLE_W-1:0] i_right_sample;
    logic                       o_out_valid;
    logic                       i_out_stall;
    logic signed [SAMPLE_W-1:0] o_out_sample;
    logic                       o_last_of_run;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index;
    logic [COEF_W-1:0]          i_cfg_data;

    mono_lowpass_linear_resampler_unit DUT (.*);

    // predictor copy of configuration and state
    logic        cfg_enable;
    logic        cfg_two_ch;
    logic [20:0] cfg_step;
    longint      coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
    longint      stage_s1 [2];
    longint      stage_s2 [2];
    longint      prev_filtered;
    longint      phase_pos;

    t_resampled  pending_samples [$];
    int          fail_count;
    bit          quiet;

    // stable 7 kHz low-pass at 48 kHz, Q 0.707
    localparam int LP_B0 = 525127;
    localparam int LP_B1 = 1050254;
    localparam int LP_A1 = -3271557;
    localparam int LP_A2 = 1179019;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("[mono_lowpass_linear_resampler_unit] ERROR");
        $finish;
    end

    function automatic longint sat_to(longint v, int w);
        longint hi;
        hi = (longint'(1) <<< (w - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic longint scale_round(longint sum);
        return sat_to((sum + (longint'(1) <<< (COEF_FRAC - 1))) >>> COEF_FRAC, STATE_W);
    endfunction

    function automatic longint biquad_stage(int k, longint x);
        longint y, n1, n2;
        y  = scale_round(coef_b0 * x + (stage_s1[k] <<< COEF_FRAC));
        n1 = scale_round(coef_b1 * x - coef_a1 * y + (stage_s2[k] <<< COEF_FRAC));
        n2 = scale_round(coef_b2 * x - coef_a2 * y);
        stage_s1[k] = n1;
        stage_s2[k] = n2;
        return y;
    endfunction

    function automatic void predict_resample(logic signed [SAMPLE_W-1:0] l,
                                             logic signed [SAMPLE_W-1:0] r);
        longint     x, cur, step, d;
        int         n;
        t_resampled e;
        if (!cfg_enable) return;
        x = cfg_two_ch ? ((longint'(l) + longint'(r)) >>> 1) : longint'(l);
        x = biquad_stage(0, x);
        x = biquad_stage(1, x);
        cur = sat_to(x, SAMPLE_W);
        step = cfg_step;
        if (step < STEP_MIN) step = STEP_MIN;
        if (step > STEP_MAX) step = STEP_MAX;
        n = 0;
        while (phase_pos < PHASE_ONE && n < 2) begin
            d = (cur - prev_filtered) * phase_pos + 32768;
            e.sample = SAMPLE_W'(sat_to(prev_filtered + (d >>> 16), SAMPLE_W));
            e.last = 1'b0;
            pending_samples = {pending_samples, e};
            n++;
            phase_pos += step;
        end
        if (n > 0) pending_samples[pending_samples.size() - 1].last = 1'b1;
        phase_pos = (phase_pos - PHASE_ONE) & 64'h1FFFFF;
        prev_filtered = cur;
    endfunction

    function automatic void predict_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] v);
        case (idx)
            REG_ENABLE: cfg_enable = v[0];
            REG_TWO_CH: cfg_two_ch = v[0];
            REG_STEP:   cfg_step   = v[20:0];
            REG_B0:     coef_b0    = longint'($signed(v));
            REG_B1:     coef_b1    = longint'($signed(v));
            REG_B2:     coef_b2    = longint'($signed(v));
            REG_A1:     coef_a1    = longint'($signed(v));
            REG_A2:     coef_a2    = longint'($signed(v));
            default: ;
        endcase
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_resampled e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_samples.size() == 0) begin
                $display("%0t: unexpected result sample=%0d last=%0d", $time,
                         o_out_sample, o_last_of_run);
                fail_count++;
            end else begin
                e = pending_samples.pop_front();
                if (o_out_sample !== e.sample) begin
                    $display("%0t: out_sample expected %0d actual %0d", $time,
                             e.sample, o_out_sample);
                    fail_count++;
                end
                if (o_last_of_run !== e.last) begin
                    $display("%0t: last_of_run expected %0d actual %0d", $time,
                             e.last, o_last_of_run);
                    fail_count++;
                end
            end
        end
    end

    // receiver back-pressure in bursts
    initial begin
        i_out_stall = 1'b0;
        forever begin
            if (quiet || $urandom_range(0, 2) == 0) begin
                @(posedge i_clk) i_out_stall <= 1'b0;
            end else begin
                @(posedge i_clk) i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 13) - 1) @(posedge i_clk);
                @(posedge i_clk) i_out_stall <= 1'b0;
                repeat ($urandom_range(0, 20)) @(posedge i_clk);
            end
        end
    end

    // called on a clock edge; returns on the edge that accepts the transaction, or after a random idle gap
    task automatic send_sample(logic signed [SAMPLE_W-1:0] l, logic signed [SAMPLE_W-1:0] r);
        i_in_valid     <= 1'b1;
        i_left_sample  <= l;
        i_right_sample <= r;
        do @(posedge i_clk); while (o_in_stall);
        predict_resample(l, r);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    task automatic send_random(int n);
        repeat (n) send_sample($urandom, $urandom);
    endtask

    // let the block go idle: results drained, then its full latency again
    task automatic drain;
        i_in_valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge i_clk);
        repeat (800) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        predict_reg(idx, v);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_coefs(int b0, int b1, int b2, int a1, int a2);
        write_reg(REG_B0, COEF_W'(b0));
        write_reg(REG_B1, COEF_W'(b1));
        write_reg(REG_B2, COEF_W'(b2));
        write_reg(REG_A1, COEF_W'(a1));
        write_reg(REG_A2, COEF_W'(a2));
    endtask

    task automatic test_reset_defaults;
        // zero coefficients: first item silent, then zeros at step 3.0
        send_sample(16'sh7FFF, 16'sh7FFF);
        send_sample(-16'sh8000, 16'sh1234);
        send_sample(16'sh0001, -16'sh0001);
        drain();
    endtask

    task automatic test_directed_extremes;
        set_coefs(LP_B0, LP_B1, LP_B0, LP_A1, LP_A2);
        write_reg(REG_STEP, 24'd32768);
        send_sample(16'sh7FFF, 16'sh7FFF);
        send_sample(-16'sh8000, -16'sh8000);
        // average of odd negative sum rounds down
        send_sample(-16'sh8000, 16'sh7FFF);
        send_sample(-16'sh0001, 16'sh0000);
        send_sample(16'sh7FFF, -16'sh8000);
        drain();
        write_reg(REG_TWO_CH, 24'hFFFFFE);
        write_reg(REG_STEP, 24'd1048576);
        send_sample(16'sh7FFF, -16'sh8000);
        send_sample(-16'sh8000, 16'sh7FFF);
        send_sample(16'sh0000, 16'sh0000);
        send_sample(16'sh5555, 16'shAAAA);
        drain();
        // steps outside the legal range get clamped
        write_reg(REG_STEP, 24'd0);
        send_sample(16'sh4000, 0);
        send_sample(-16'sh4000, 0);
        send_sample(16'sh7FFF, 0);
        drain();
        write_reg(REG_STEP, 24'hFFFFFF);
        send_sample(16'sh7FFF, 0);
        send_sample(-16'sh8000, 0);
        send_sample(16'sh7FFF, 0);
        drain();
    endtask

    task automatic test_filter_overflow;
        write_reg(REG_TWO_CH, 24'd1);
        write_reg(REG_STEP, 24'd65536);
        set_coefs(8388607, 8388607, 8388607, -8388608, -8388608);
        send_sample(16'sh7FFF, 16'sh7FFF);
        send_sample(16'sh7FFF, 16'sh7FFF);
        send_sample(-16'sh8000, -16'sh8000);
        send_random(12);
        drain();
        set_coefs(-8388608, -8388608, -8388608, 8388607, 8388607);
        send_random(20);
        drain();
    endtask

    task automatic test_disabled;
        set_coefs(LP_B0, LP_B1, LP_B0, LP_A1, LP_A2);
        write_reg(REG_ENABLE, 24'd0);
        send_random(15);
        drain();
        write_reg(REG_ENABLE, 24'hFFFFFF);
        send_random(15);
        drain();
    endtask

    task automatic test_random_phases;
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(REG_TWO_CH, COEF_W'($urandom));
            case ($urandom_range(0, 3))
                0: write_reg(REG_STEP, 24'd32768);
                1: write_reg(REG_STEP, 24'd1048576);
                default: write_reg(REG_STEP, COEF_W'($urandom_range(32768, 1048576)));
            endcase
            if ($urandom_range(0, 3) == 0)
                set_coefs($urandom, $urandom, $urandom, $urandom, $urandom);
            else
                set_coefs(LP_B0 + $urandom_range(0, 4000) - 2000, LP_B1, LP_B0,
                          LP_A1 + $urandom_range(0, 4000) - 2000, LP_A2);
            if (ph == 5) quiet = 1'b1;
            send_random(125);
            drain();
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_left_sample  = '0;
        i_right_sample = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        fail_count     = 0;
        quiet          = 1'b0;
        cfg_enable     = 1'b1;
        cfg_two_ch     = 1'b1;
        cfg_step       = 21'd196608;
        coef_b0 = 0; coef_b1 = 0; coef_b2 = 0; coef_a1 = 0; coef_a2 = 0;
        stage_s1 = '{0, 0};
        stage_s2 = '{0, 0};
        prev_filtered  = 0;
        phase_pos      = PHASE_ONE;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        test_reset_defaults();
        test_directed_extremes();
        test_filter_overflow();
        test_disabled();
        test_random_phases();

        repeat (400) @(posedge i_clk);
        if (fail_count == 0 && pending_samples.size() == 0) begin
            $display("[mono_lowpass_linear_resampler_unit] OK");
        end else begin
            $display("[mono_lowpass_linear_resampler_unit] ERROR");
        end
        $finish;
    end

endmodule
